// File: hdl/kcf_pkg.sv
// Shared types, constants and helpers for the key chatter filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package kcf_pkg;

    // Key table geometry and tick limits.
    localparam int NUM_KEYS              = 768;
    localparam int KEY_AW                = $clog2(NUM_KEYS);
    localparam int MAX_RELEASES_PER_TICK = 32;
    localparam int EXP_W                 = $clog2(MAX_RELEASES_PER_TICK + 1);

    // Field widths.
    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 32;
    localparam int WIN_W   = 10;
    localparam int TDATA_W = TYPE_W + CODE_W + VALUE_W;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = WIN_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GAME_BYPASS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 2'd2;
    localparam logic [WIN_W-1:0]     WINDOW_MS_RESET   = 10'd30;

    // Event codes.
    localparam logic [TYPE_W-1:0] EV_KEY      = 16'd1;
    localparam logic [TYPE_W-1:0] EV_SYN      = 16'd0;
    localparam logic [CODE_W-1:0] REPORT_CODE = 16'd0;

    // Keys that game bypass lets through untouched.
    localparam logic [CODE_W-1:0] GAME_KEY_W = 16'd17;
    localparam logic [CODE_W-1:0] GAME_KEY_A = 16'd30;
    localparam logic [CODE_W-1:0] GAME_KEY_S = 16'd31;
    localparam logic [CODE_W-1:0] GAME_KEY_D = 16'd32;

    // One key table entry: remaining ticks and window flags.
    typedef struct packed {
        logic [WIN_W-1:0] count;
        logic             is_open;
        logic             chat;
        logic             held;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EV_RD,
        S_EV_EVAL,
        S_EV_FWD,
        S_EV_FWD_M,
        S_EV_MARK,
        S_TK_RD,
        S_TK_EVAL,
        S_TK_PKEY,
        S_TK_PMARK,
        S_TK_FKEY,
        S_TK_FMARK
    } t_state;

    typedef enum logic [1:0] {
        RD_CODE,
        RD_IDX,
        RD_IDX_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        OUT_INPUT,
        OUT_MARK,
        OUT_PEND
    } t_out_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     in_take;
        logic     scan_init;
        logic     mem_rd;
        t_rd_sel  rd_sel;
        logic     idx_inc;
        logic     clr_wr;
        logic     ev_commit;
        logic     tk_commit;
        logic     pend_set;
        logic     pend_clr;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_tick;
        logic in_key;
        logic ev_fwd;
        logic ev_mark;
        logic tk_emit;
        logic pend_valid;
        logic idx_last;
        logic out_free;
    } t_status;

    function automatic logic is_game_key(input logic [CODE_W-1:0] code);
        return (code == GAME_KEY_W) || (code == GAME_KEY_A) ||
               (code == GAME_KEY_S) || (code == GAME_KEY_D);
    endfunction

endpackage

`default_nettype wire

// File: hdl/kcf_ctrl.sv
// Sequencing controller of the key chatter filter.
// Depends on kcf_pkg; drives the datapath through t_cmd and reads t_status.
`default_nettype none

module kcf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_valid,
    output logic             o_s_ready,
    input  kcf_pkg::t_status i_st,
    output kcf_pkg::t_cmd    o_cmd
);
    import kcf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_st.idx_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    if (i_st.in_tick)     n_state = S_TK_RD;
                    else if (i_st.in_key) n_state = S_EV_RD;
                    else                  n_state = S_EV_FWD;
                end
            end
            S_EV_RD:   n_state = S_EV_EVAL;
            S_EV_EVAL: begin
                if (i_st.ev_fwd && i_st.ev_mark) n_state = S_EV_FWD_M;
                else if (i_st.ev_fwd)            n_state = S_EV_FWD;
                else                             n_state = S_IDLE;
            end
            S_EV_FWD: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            S_EV_FWD_M: begin
                if (i_st.out_free) n_state = S_EV_MARK;
            end
            S_EV_MARK: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            S_TK_RD:   n_state = S_TK_EVAL;
            S_TK_EVAL: begin
                if (i_st.tk_emit && i_st.pend_valid) begin
                    n_state = S_TK_PKEY;
                end else if (i_st.idx_last) begin
                    n_state = (i_st.pend_valid || i_st.tk_emit) ? S_TK_FKEY : S_IDLE;
                end
            end
            S_TK_PKEY: begin
                if (i_st.out_free) n_state = S_TK_PMARK;
            end
            S_TK_PMARK: begin
                if (i_st.out_free) n_state = i_st.idx_last ? S_TK_FKEY : S_TK_RD;
            end
            S_TK_FKEY: begin
                if (i_st.out_free) n_state = S_TK_FMARK;
            end
            S_TK_FMARK: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_IDX;
        o_cmd.out_sel = OUT_INPUT;
        o_s_ready     = (r_state == S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.idx_inc = !i_st.idx_last;
            end
            S_IDLE: begin
                o_cmd.in_take   = i_s_valid;
                o_cmd.scan_init = i_s_valid && i_st.in_tick;
            end
            S_EV_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = RD_CODE;
            end
            S_EV_EVAL: begin
                o_cmd.ev_commit = 1'b1;
            end
            S_EV_FWD: begin
                o_cmd.out_load = i_st.out_free;
                o_cmd.out_sel  = OUT_INPUT;
                o_cmd.out_last = 1'b1;
            end
            S_EV_FWD_M: begin
                o_cmd.out_load = i_st.out_free;
                o_cmd.out_sel  = OUT_INPUT;
            end
            S_EV_MARK: begin
                o_cmd.out_load = i_st.out_free;
                o_cmd.out_sel  = OUT_MARK;
                o_cmd.out_last = 1'b1;
            end
            S_TK_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = RD_IDX;
            end
            S_TK_EVAL: begin
                o_cmd.tk_commit = 1'b1;
                if (!(i_st.tk_emit && i_st.pend_valid)) begin
                    o_cmd.pend_set = i_st.tk_emit;
                    if (!i_st.idx_last) begin
                        o_cmd.mem_rd  = 1'b1;
                        o_cmd.rd_sel  = RD_IDX_NEXT;
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_TK_PKEY: begin
                o_cmd.out_load = i_st.out_free;
                o_cmd.out_sel  = OUT_PEND;
            end
            S_TK_PMARK: begin
                o_cmd.out_load = i_st.out_free;
                o_cmd.out_sel  = OUT_MARK;
                o_cmd.pend_set = i_st.out_free;
                o_cmd.idx_inc  = i_st.out_free && !i_st.idx_last;
            end
            S_TK_FKEY: begin
                o_cmd.out_load = i_st.out_free;
                o_cmd.out_sel  = OUT_PEND;
            end
            S_TK_FMARK: begin
                o_cmd.out_load = i_st.out_free;
                o_cmd.out_sel  = OUT_MARK;
                o_cmd.out_last = 1'b1;
                o_cmd.pend_clr = i_st.out_free;
            end
            default: o_cmd.out_sel = OUT_INPUT;
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/kcf_datapath.sv
// Datapath of the key chatter filter: settings, key table memory,
// window arithmetic and the output register. Depends on kcf_pkg.
`default_nettype none

module kcf_datapath (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [kcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [kcf_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire  [kcf_pkg::TDATA_W-1:0]    i_s_tdata,
    input  wire                            i_s_tuser,
    input  kcf_pkg::t_cmd                  i_cmd,
    output kcf_pkg::t_status               o_st,
    input  wire                            i_m_tready,
    output logic                           o_m_tvalid,
    output logic [kcf_pkg::TDATA_W-1:0]    o_m_tdata,
    output logic                           o_m_tlast
);
    import kcf_pkg::*;

    // Settings.
    logic             r_game_bypass;
    logic             r_delay;
    logic [WIN_W-1:0] r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_game_bypass <= 1'b0;
            r_delay       <= 1'b0;
            r_window      <= WINDOW_MS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAME_BYPASS:   r_game_bypass <= i_cfg_data[0];
                CFG_DELAY_RELEASE: r_delay       <= i_cfg_data[0];
                CFG_WINDOW_MS:     r_window      <= i_cfg_data[WIN_W-1:0];
                default:           r_window      <= r_window;
            endcase
        end
    end

    // Request being worked on.
    logic [TYPE_W-1:0]  r_type;
    logic [CODE_W-1:0]  r_code;
    logic [VALUE_W-1:0] r_value;

    logic [TYPE_W-1:0]  in_type;
    logic [CODE_W-1:0]  in_code;
    logic [VALUE_W-1:0] in_value;

    assign in_type  = i_s_tdata[TYPE_W-1:0];
    assign in_code  = i_s_tdata[TYPE_W+CODE_W-1:TYPE_W];
    assign in_value = i_s_tdata[TDATA_W-1:TYPE_W+CODE_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_type  <= in_type;
            r_code  <= in_code;
            r_value <= in_value;
        end
    end

    // Scan index, expiry count and the release waiting for its report marker.
    logic [KEY_AW-1:0] r_idx;
    logic [EXP_W-1:0]  r_exp;
    logic              r_pend_valid;
    logic [KEY_AW-1:0] r_pend_code;

    logic [KEY_AW-1:0] idx_next;
    logic              idx_last;

    assign idx_next = r_idx + 1'b1;
    assign idx_last = (r_idx == KEY_AW'(NUM_KEYS - 1));

    // Key table.
    t_entry            r_mem [NUM_KEYS];
    t_entry            r_rd_data;
    logic [KEY_AW-1:0] rd_addr;
    logic              wr_en;
    logic [KEY_AW-1:0] wr_addr;
    t_entry            wr_data;
    t_entry            ev_new;
    t_entry            tk_new;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_CODE:     rd_addr = r_code[KEY_AW-1:0];
            RD_IDX_NEXT: rd_addr = idx_next;
            default:     rd_addr = r_idx;
        endcase
    end

    assign wr_en   = i_cmd.clr_wr || i_cmd.ev_commit || i_cmd.tk_commit;
    assign wr_addr = i_cmd.ev_commit ? r_code[KEY_AW-1:0] : r_idx;
    assign wr_data = i_cmd.clr_wr ? t_entry'('0) : (i_cmd.ev_commit ? ev_new : tk_new);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Key event evaluation.
    logic bypass;
    logic is_release;
    logic hold;
    logic win_zero;
    logic chatter;

    assign bypass     = r_game_bypass && is_game_key(r_code);
    assign is_release = !r_value[0];
    assign hold       = r_delay && !bypass;
    assign win_zero   = (r_window == '0);
    assign chatter    = !bypass && r_rd_data.is_open;

    always_comb begin
        ev_new = r_rd_data;
        if (is_release) begin
            if (win_zero) begin
                ev_new = '0;
            end else begin
                ev_new.count   = r_window;
                ev_new.is_open = 1'b1;
                ev_new.chat    = 1'b0;
                ev_new.held    = hold;
            end
        end else if (chatter) begin
            ev_new.chat = 1'b1;
        end
    end

    // Tick evaluation of the entry at r_idx.
    logic tk_due;
    logic tk_expire;

    assign tk_due    = r_rd_data.is_open && (r_rd_data.count <= WIN_W'(1));
    assign tk_expire = tk_due && (r_exp < EXP_W'(MAX_RELEASES_PER_TICK));

    always_comb begin
        tk_new = r_rd_data;
        if (r_rd_data.is_open) begin
            if (!tk_due) begin
                tk_new.count = r_rd_data.count - 1'b1;
            end else if (!tk_expire) begin
                tk_new.count = '0;
            end else begin
                tk_new = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_exp        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_idx <= '0;
                r_exp <= '0;
            end else begin
                if (i_cmd.idx_inc) r_idx <= idx_next;
                if (i_cmd.tk_commit && tk_expire) r_exp <= r_exp + 1'b1;
            end
            if (i_cmd.scan_init || i_cmd.pend_clr) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.pend_set) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_set) begin
            r_pend_code <= r_idx;
        end
    end

    // Output register.
    logic                r_out_valid;
    logic [TDATA_W-1:0]  r_out_data;
    logic                r_out_last;
    logic [TDATA_W-1:0]  out_sel_data;

    always_comb begin
        unique case (i_cmd.out_sel)
            OUT_MARK: out_sel_data = {VALUE_W'(0), REPORT_CODE, EV_SYN};
            OUT_PEND: out_sel_data = {VALUE_W'(0), CODE_W'(r_pend_code), EV_KEY};
            default:  out_sel_data = {r_value, r_code, r_type};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= out_sel_data;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // Status.
    assign o_st.in_tick    = i_s_tuser;
    assign o_st.in_key     = (in_type == EV_KEY) && (in_code < CODE_W'(NUM_KEYS)) &&
                             (in_value[VALUE_W-1:1] == '0);
    assign o_st.ev_fwd     = is_release ? (!hold || win_zero) : !chatter;
    assign o_st.ev_mark    = is_release && win_zero && hold;
    assign o_st.tk_emit    = tk_expire && r_rd_data.held && !r_rd_data.chat && r_delay;
    assign o_st.pend_valid = r_pend_valid;
    assign o_st.idx_last   = idx_last;
    assign o_st.out_free   = !r_out_valid || i_m_tready;

endmodule

`default_nettype wire

// File: hdl/key_chatter_filter.sv
// Top level of the key chatter filter: controller plus datapath.
// Depends on kcf_pkg, kcf_ctrl and kcf_datapath.
//
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         tdata: event_type, event_code, event_value; tuser: command
//  m_axis    out        tdata: out_type, out_code, out_value; tlast: last_of_run
//  i_cfg_*   in         index 0 game_bypass, 1 delay_release, 2 window_ms
//
// A key event for a key in the table reads and evaluates its entry, then
// forwards any results; any other device event is forwarded directly. A tick
// walks all NUM_KEYS entries, one per cycle unless a result is being output;
// each held release found while another waits is sent with a report marker, as is the final one.
// Reset clears all NUM_KEYS (768) key table entries with s_axis_tready low.
// A stalled m_axis stops the controller only when it has another result ready.
`default_nettype none

module key_chatter_filter (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration write port.
    input  wire                            i_cfg_we,
    input  wire  [kcf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [kcf_pkg::CFG_W-1:0]      i_cfg_data,
    // Input requests.
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: [15:0] event_type, [31:16] event_code, [63:32] event_value
    input  wire  [kcf_pkg::TDATA_W-1:0]    s_axis_tdata,
    // tuser: [0] command (0 device event, 1 millisecond tick)
    input  wire                            s_axis_tuser,
    // Result requests.
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // tdata: [15:0] out_type, [31:16] out_code, [63:32] out_value
    output logic [kcf_pkg::TDATA_W-1:0]    m_axis_tdata,
    output logic                           m_axis_tlast
);
    import kcf_pkg::*;

    t_cmd    cmd;
    t_status st;

    // The controller sequences the table clear, event lookups and tick scans.
    kcf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    // The datapath holds the settings, key table and output register.
    kcf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: hdl/kcf_checker.sv
// Port-level checks for the key chatter filter, bound to the top level.
// Depends on kcf_pkg and key_chatter_filter.
`default_nettype none

module kcf_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_s_tvalid,
    input wire                         i_s_tready,
    input wire                         i_m_tvalid,
    input wire                         i_m_tready,
    input wire [kcf_pkg::TDATA_W-1:0]  i_m_tdata,
    input wire                         i_m_tlast
);
    import kcf_pkg::*;

    // A stalled result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("result changed while stalled");

    // The table clear follows every reset, so no request is taken right after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_s_tready)
        else $error("input ready during key table clear");

    // One request at a time: ready drops after each accepted request.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second request taken while busy");

    // Results are produced only while a request is being worked on.
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_m_tvalid) |-> $past(!i_s_tready))
        else $error("result appeared while idle");

endmodule

bind key_chatter_filter kcf_checker u_kcf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);

`default_nettype wire
